// File: rtl/bfa_pkg.sv
// bfa_pkg: shared types, codes and helpers of the bitmap frame allocator
// no dependencies; used by bfa_scan_unit and bitmap_frame_allocator
`default_nettype none

package bfa_pkg;

  // bitmap word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam logic [WORD_BITS-1:0] ALL_USED = 32'hFFFF_FFFF;

  // frame count register
  localparam int unsigned TOTAL_W = 13;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  // command codes (tuser of the input beat)
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RESERVE = 2'd2;

  // status codes (tuser of the result beat)
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_OOM   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // verdict of the scan unit on one bitmap word
  typedef struct packed {
    logic             hit;      // free frame below the limit found in this word
    logic             stop;     // scan ends here without a free frame
    logic [BIT_W-1:0] bit_idx;  // lowest clear bit of the word
  } scan_res_t;

  // lowest clear bit of a word, msb set when there is one
  function automatic logic [BIT_W:0] lowest_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_W:0] res;
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res = {1'b1, BIT_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bfa_bitmap_mem.sv
// bfa_bitmap_mem: used/free bitmap storage, one write and one read port
// registered read data; no dependencies
`default_nettype none

module bfa_bitmap_mem #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [31:0]       wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [31:0]       rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered and valid in the cycle after the address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/bfa_scan_unit.sv
// bfa_scan_unit: checks one bitmap word against the scan limit
// depends on bfa_pkg
`default_nettype none

module bfa_scan_unit #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned LIM_W  = 13
) (
  input  wire logic [31:0]       word_i,
  input  wire logic [ADDR_W-1:0] word_idx_i,
  input  wire logic [LIM_W-1:0]  limit_i,
  output bfa_pkg::scan_res_t     res_o
);

  localparam int unsigned CMP_W = (ADDR_W + 6 > LIM_W) ? ADDR_W + 6 : LIM_W;

  logic [bfa_pkg::BIT_W:0] zero;
  logic [CMP_W-1:0]        frame;
  logic [CMP_W-1:0]        next_base;
  logic [CMP_W-1:0]        lim;
  logic                    last_word;
  logic                    hit;

  // lowest free frame of the word and the bounds around it
  assign zero      = bfa_pkg::lowest_zero(word_i);
  assign frame     = CMP_W'({word_idx_i, zero[bfa_pkg::BIT_W-1:0]});
  assign next_base = CMP_W'({word_idx_i, {bfa_pkg::BIT_W{1'b0}}}) + CMP_W'(bfa_pkg::WORD_BITS);
  assign lim       = CMP_W'(limit_i);
  assign last_word = (word_idx_i == ADDR_W'(DEPTH - 1));

  // a clear bit at or past the limit ends the scan like a full last word
  assign hit = zero[bfa_pkg::BIT_W] && (frame < lim);

  assign res_o.hit     = hit;
  assign res_o.stop    = !hit && (zero[bfa_pkg::BIT_W] || last_word || (next_base >= lim));
  assign res_o.bit_idx = zero[bfa_pkg::BIT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/bitmap_frame_allocator.sv
// bitmap_frame_allocator: first-fit page frame allocator over a used/free bitmap
// depends on bfa_pkg, bfa_bitmap_mem, bfa_scan_unit
//
//  channel  | dir | tdata                 | tuser
//  s_axis   | in  | physical_address[31:0]| command[1:0]
//  m_axis   | out | frame_address[31:0]   | status[1:0]
//  cfg      | in  | total_frames[12:0] on cfg_wdata_i, written when cfg_we_i
//
// allocate reads and checks one bitmap word per cycle through the shared scan
// unit, then writes the updated word in ST_AWR; the scan ends early
// at the first free frame or once the frame count is passed
// free and reserve go through read, modify-write and result; command 3 and a
// free or reserve past the bitmap go straight to the result
// after reset a clearing pass writes all ones into every bitmap word,
// with s_axis_tready_o low; cfg writes are taken throughout
// a result beat waits in the output register; the next beat is taken meanwhile
// and its result stalls only if the previous one is still not taken
// PAGE_BYTES must be a power of two
`default_nettype none

module bitmap_frame_allocator #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input beats
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] physical_address
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] command
  // result beats
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,   // [31:0] frame_address
  output logic      [1:0]  m_axis_tuser_o,   // [1:0] status
  // frame count register
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i
);

  localparam int unsigned WORDS      = (MAX_FRAMES + 31) / 32;
  localparam int unsigned ADDR_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FW         = ADDR_W + bfa_pkg::BIT_W;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned LIM_RAW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned LIM_W      = (LIM_RAW > bfa_pkg::TOTAL_W) ? LIM_RAW : bfa_pkg::TOTAL_W;

  // sequencer states
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_AWR    = 3'd3;
  localparam logic [2:0] ST_RMW_RD = 3'd4;
  localparam logic [2:0] ST_RMW_WR = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [ADDR_W:0]            cnt_q, cnt_d;
  logic                       chk_v_q, chk_v_d;
  logic [ADDR_W-1:0]          chk_idx_q, chk_idx_d;
  logic [FW-1:0]              tgt_q, tgt_d;
  logic [1:0]                 cmd_q, cmd_d;
  logic [31:0]                wword_q, wword_d;
  logic [31:0]                res_addr_q, res_addr_d;
  logic [1:0]                 res_stat_q, res_stat_d;
  logic [bfa_pkg::TOTAL_W-1:0] total_q;
  logic                       out_v_q;
  logic [31:0]                out_addr_q;
  logic [1:0]                 out_stat_q;

  logic                       mem_we, mem_re;
  logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [31:0]                mem_wdata, mem_rdata;
  logic [31:0]                tgt_mask;
  logic [31:0]                hit_mask;
  logic [LIM_W-1:0]           eff_lim;
  logic [31:0]                addr_frame;
  logic                       addr_in_range;
  logic [FW-1:0]              hit_frame;
  logic [63:0]                hit_addr64;
  logic                       cnt_live;
  logic                       out_load;
  bfa_pkg::scan_res_t         scan_res;

  // frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= bfa_pkg::TOTAL_RESET;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // scan covers min(total_frames, MAX_FRAMES) frames
  assign eff_lim = (LIM_W'(total_q) < LIM_W'(MAX_FRAMES)) ? LIM_W'(total_q) : LIM_W'(MAX_FRAMES);

  // frame of a free/reserve address
  assign addr_frame    = s_axis_tdata_i >> PAGE_SHIFT;
  assign addr_in_range = ({1'b0, addr_frame} < 33'(MAX_FRAMES));

  // shared scan unit on the word read last cycle
  bfa_scan_unit #(
    .DEPTH  (WORDS),
    .ADDR_W (ADDR_W),
    .LIM_W  (LIM_W)
  ) u_scan (
    .word_i     (mem_rdata),
    .word_idx_i (chk_idx_q),
    .limit_i    (eff_lim),
    .res_o      (scan_res)
  );

  assign hit_frame  = {chk_idx_q, scan_res.bit_idx};
  assign hit_addr64 = 64'(hit_frame) << PAGE_SHIFT;
  assign hit_mask   = 32'(1) << scan_res.bit_idx;
  assign tgt_mask   = 32'(1) << tgt_q[bfa_pkg::BIT_W-1:0];
  assign cnt_live   = (cnt_q < (ADDR_W + 1)'(WORDS));

  // bitmap ports
  assign mem_re    = ((state_q == ST_SCAN) && cnt_live) || (state_q == ST_RMW_RD);
  assign mem_raddr = (state_q == ST_RMW_RD) ? tgt_q[FW-1:bfa_pkg::BIT_W] : cnt_q[ADDR_W-1:0];
  assign mem_we    = (state_q == ST_INIT) || (state_q == ST_AWR) || (state_q == ST_RMW_WR);
  assign mem_waddr = (state_q == ST_INIT) ? cnt_q[ADDR_W-1:0] : tgt_q[FW-1:bfa_pkg::BIT_W];

  always_comb begin
    case (state_q)
      ST_INIT: mem_wdata = bfa_pkg::ALL_USED;
      ST_AWR:  mem_wdata = wword_q;
      default: mem_wdata = (cmd_q == bfa_pkg::CMD_FREE) ? (mem_rdata & ~tgt_mask)
                                                        : (mem_rdata | tgt_mask);
    endcase
  end

  bfa_bitmap_mem #(
    .DEPTH  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_load        = (state_q == ST_FINISH) && (!out_v_q || m_axis_tready_i);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    chk_v_d    = chk_v_q;
    chk_idx_d  = chk_idx_q;
    tgt_d      = tgt_q;
    cmd_d      = cmd_q;
    wword_d    = wword_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    case (state_q)
      ST_INIT: begin
        cnt_d = cnt_q + (ADDR_W + 1)'(1);
        if (cnt_q == (ADDR_W + 1)'(WORDS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d      = s_axis_tuser_i;
          res_addr_d = '0;
          res_stat_d = bfa_pkg::STAT_DONE;
          case (s_axis_tuser_i)
            bfa_pkg::CMD_ALLOC: begin
              cnt_d   = '0;
              chk_v_d = 1'b0;
              state_d = ST_SCAN;
            end
            bfa_pkg::CMD_FREE, bfa_pkg::CMD_RESERVE: begin
              if (addr_in_range) begin
                tgt_d   = addr_frame[FW-1:0];
                state_d = ST_RMW_RD;
              end else begin
                res_stat_d = bfa_pkg::STAT_RANGE;
                state_d    = ST_FINISH;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read one word ahead while the previous one is checked
        if (cnt_live) begin
          cnt_d = cnt_q + (ADDR_W + 1)'(1);
        end
        chk_v_d   = cnt_live;
        chk_idx_d = cnt_q[ADDR_W-1:0];
        if (chk_v_q) begin
          if (scan_res.hit) begin
            tgt_d      = hit_frame;
            wword_d    = mem_rdata | hit_mask;
            res_addr_d = hit_addr64[31:0];
            res_stat_d = bfa_pkg::STAT_DONE;
            chk_v_d    = 1'b0;
            state_d    = ST_AWR;
          end else if (scan_res.stop) begin
            res_addr_d = '0;
            res_stat_d = bfa_pkg::STAT_OOM;
            chk_v_d    = 1'b0;
            state_d    = ST_FINISH;
          end
        end
      end
      ST_AWR: begin
        state_d = ST_FINISH;
      end
      ST_RMW_RD: begin
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_v_q <= chk_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    tgt_q      <= tgt_d;
    cmd_q      <= cmd_d;
    wword_q    <= wword_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
  end

  // result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_stat_q;

  // no beat is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !s_axis_tready_o)
    else $error("input taken during bitmap clearing pass");

  // a new result only comes out of the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FINISH))
    else $error("result beat without a finished command");

  // a nonzero frame address is only given with a done status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o != 32'd0)) |-> (m_axis_tuser_o == bfa_pkg::STAT_DONE))
    else $error("frame address given with an error status");

  // the allocate write always follows a hit of the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AWR) |-> $past(state_q == ST_SCAN && chk_v_q && scan_res.hit))
    else $error("bitmap allocate write without a scan hit");

endmodule

`default_nettype wire
